[src/wsf_pkg.sv]
// Shared types and constants for the waveform span and frequency block.
`timescale 1ns / 1ps
`default_nettype none
package wsf_pkg;
    localparam int BufferDepth  = 1024;
    localparam int AddrW        = $clog2(BufferDepth);
    localparam int FillW        = AddrW + 1;
    localparam int MaxCrossings = 50;
    localparam int CountW       = 6;
    localparam int CrossingLag  = 5;
    localparam int NumW         = 42;   // (count-1)*1e6 << 16 fits in 42 bits
    localparam int QuotW        = 64;
    localparam logic [19:0] UsPerSecond = 20'd1000000;
    localparam logic [NumW-1:0] FreqMax = {NumW{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD, ST_SCAN, ST_DIV, ST_RESULT
    } state_t;

    typedef struct packed {
        logic load;       // store accepted sample
        logic scan_start; // begin crossing pass
        logic scan_en;    // read and test next entry
        logic div_start;
        logic clear;      // end of block
    } ctrl_t;

    typedef struct packed {
        logic scan_done;
        logic div_done;
    } stat_t;
endpackage
`default_nettype wire

[src/wsf_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module wsf_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

[src/wsf_ctrl.sv]
// Controller: load, crossing pass, divide, result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module wsf_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    input  wire logic           s_last,
    output logic                s_ready,
    output logic                m_valid,
    input  wire logic           m_ready,
    input  wire wsf_pkg::stat_t stat,
    output wsf_pkg::ctrl_t      ctrl
);
    import wsf_pkg::*;
    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_LOAD;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        ctrl = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.load = 1'b1;
                    if (s_last) begin
                        ctrl.scan_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                ctrl.scan_en = 1'b1;
                if (stat.scan_done) begin
                    ctrl.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: if (stat.div_done) state_next = ST_RESULT;
            ST_RESULT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    ctrl.clear = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("input and result both open");
    a_scan_to_div: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.div_start |=> state_reg == ST_DIV) else $error("divide not entered");
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.clear |=> s_ready) else $error("not back to load");
endmodule
`default_nettype wire

[src/wsf_dp.sv]
// Datapath: sample stores, max/min, crossing detector and divider.
`timescale 1ns / 1ps
`default_nettype none
module wsf_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire wsf_pkg::ctrl_t      ctrl,
    output wsf_pkg::stat_t           stat,
    input  wire logic signed [15:0]  s_sample,
    input  wire logic        [31:0]  s_timestamp_us,
    output logic signed      [15:0]  m_max_value,
    output logic signed      [15:0]  m_min_value,
    output logic             [15:0]  m_peak_to_peak,
    output logic             [5:0]   m_crossing_count,
    output logic             [41:0]  m_freq_q16,
    output logic                     m_freq_valid,
    output logic                     m_overflow
);
    import wsf_pkg::*;

    logic [FillW-1:0] fill_reg;
    logic signed [15:0] max_reg, min_reg;
    logic drop_reg;
    logic full;
    assign full = fill_reg == FillW'(BufferDepth);

    always_ff @(posedge aclk) begin
        if (!aresetn || ctrl.clear) begin
            fill_reg <= '0;
            max_reg  <= 16'sd0;
            min_reg  <= 16'sd32767;
            drop_reg <= 1'b0;
        end else if (ctrl.load) begin
            if (full) drop_reg <= 1'b1;
            else begin
                fill_reg <= fill_reg + 1'b1;
                if (s_sample > max_reg) max_reg <= s_sample;
                if (s_sample < min_reg) min_reg <= s_sample;
            end
        end
    end

    // Scan: address counter issues reads; results arrive in the next cycle.
    logic [FillW-1:0] addr_reg;
    logic             rd_vld_reg;
    logic [FillW-1:0] rd_idx_reg;
    logic signed [15:0] samp_rd;
    logic [31:0] time_rd;
    logic we;
    assign we = ctrl.load && !full;

    wsf_ram #(.Width(16), .Depth(BufferDepth)) u_samp (
        .aclk(aclk), .we(we), .waddr(fill_reg[AddrW-1:0]), .wdata(s_sample),
        .raddr(addr_reg[AddrW-1:0]), .rdata(samp_rd));
    wsf_ram #(.Width(32), .Depth(BufferDepth)) u_time (
        .aclk(aclk), .we(we), .waddr(fill_reg[AddrW-1:0]), .wdata(s_timestamp_us),
        .raddr(addr_reg[AddrW-1:0]), .rdata(time_rd));

    // lag line of the last CrossingLag samples read
    logic signed [15:0] lag_reg [CrossingLag];
    logic signed [17:0] mid2, cur2, old2;
    assign mid2 = 18'(max_reg) + 18'(min_reg);
    assign cur2 = {samp_rd[15], samp_rd, 1'b0};
    assign old2 = {lag_reg[CrossingLag-1][15], lag_reg[CrossingLag-1], 1'b0};

    logic [CountW-1:0] cnt_reg;
    logic armed_reg;
    logic [31:0] tfirst_reg, tlast_reg;
    logic issuing;
    assign issuing = addr_reg < fill_reg;
    // only looked at by the controller during the crossing pass
    assign stat.scan_done = !issuing && !rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            addr_reg   <= '0;
            cnt_reg    <= '0;
            armed_reg  <= 1'b1;
        end else if (ctrl.scan_start) begin
            addr_reg   <= '0;
            rd_vld_reg <= 1'b0;
            cnt_reg    <= '0;
            armed_reg  <= 1'b1;
        end else if (ctrl.scan_en) begin
            rd_vld_reg <= issuing;
            rd_idx_reg <= addr_reg;
            if (issuing) addr_reg <= addr_reg + 1'b1;
            if (rd_vld_reg) begin
                for (int k = CrossingLag - 1; k > 0; k--) lag_reg[k] <= lag_reg[k-1];
                lag_reg[0] <= samp_rd;
                if (rd_idx_reg >= FillW'(CrossingLag) &&
                    cnt_reg < CountW'(MaxCrossings)) begin
                    if (cur2 > mid2 && old2 < mid2 && armed_reg) begin
                        if (cnt_reg == '0) tfirst_reg <= time_rd;
                        tlast_reg <= time_rd;
                        cnt_reg   <= cnt_reg + 1'b1;
                        armed_reg <= 1'b0;
                    end else if (cur2 < mid2 && !armed_reg) begin
                        armed_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Restoring divider, one quotient bit per cycle.
    logic [31:0] span;
    assign span = tlast_reg - tfirst_reg;
    logic [QuotW-1:0] quo_reg;
    logic [32:0] rem_reg;
    logic [NumW-1:0] num_reg;
    logic [5:0] bit_reg;
    logic busy_reg, ok_reg;
    logic [32:0] trial;
    assign trial = {rem_reg[31:0], num_reg[NumW-1]};
    assign stat.div_done = busy_reg && bit_reg == '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) busy_reg <= 1'b0;
        else if (ctrl.div_start) begin
            busy_reg <= 1'b1;
            bit_reg  <= 6'(NumW);
            rem_reg  <= '0;
            quo_reg  <= '0;
            ok_reg   <= cnt_reg >= CountW'(2) && span != 32'd0;
            num_reg  <= NumW'({26'(cnt_reg - 1'b1) * UsPerSecond, 16'd0});
        end else if (busy_reg) begin
            if (bit_reg == '0) busy_reg <= 1'b0;
            else begin
                bit_reg <= bit_reg - 1'b1;
                num_reg <= num_reg << 1;
                if (trial >= {1'b0, span}) begin
                    rem_reg <= trial - {1'b0, span};
                    quo_reg <= {quo_reg[QuotW-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    quo_reg <= {quo_reg[QuotW-2:0], 1'b0};
                end
            end
        end
    end

    assign m_max_value      = max_reg;
    assign m_min_value      = min_reg;
    assign m_peak_to_peak   = 16'(max_reg - min_reg);
    assign m_crossing_count = cnt_reg;
    assign m_freq_valid     = ok_reg;
    assign m_overflow       = drop_reg;
    assign m_freq_q16 = !ok_reg ? '0 :
                        (quo_reg > QuotW'(FreqMax)) ? FreqMax : quo_reg[NumW-1:0];

    a_cnt_max: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CountW'(MaxCrossings) || ctrl.load) else $error("count beyond max");
    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FillW'(BufferDepth)) else $error("fill beyond depth");
    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load && !full |=> !$rose(drop_reg)) else $error("drop while room");
endmodule
`default_nettype wire

[src/waveform_span_and_frequency_top.sv]
// Top level of the waveform span and frequency estimator.
//
// Samples arrive on the s_ channel, one transaction per cycle while s_ready
// is high, and fill a 1024-entry sample and timestamp store while max and min
// are tracked. Samples beyond the store depth are dropped and flagged in
// m_overflow. The transaction with s_last high closes the block: s_ready then
// drops while the crossing pass reads the store, one entry per cycle through
// the RAM read port, and a restoring divider produces the Q26.16 frequency
// one quotient bit per cycle.
// The result is held on the m_ channel until m_ready; a stalled receiver
// simply holds the block, and no new samples are taken until the result
// transaction completes. Loading runs at one sample per cycle.
// Reset (aresetn low, synchronous) empties the block: max 0, min 32767.
// The store needs no clearing, as only entries of the current block are read.
`timescale 1ns / 1ps
`default_nettype none
module waveform_span_and_frequency_top (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_sample,
    input  wire logic        [31:0] s_timestamp_us,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed      [15:0] m_max_value,
    output logic signed      [15:0] m_min_value,
    output logic             [15:0] m_peak_to_peak,
    output logic             [5:0]  m_crossing_count,
    output logic             [41:0] m_freq_q16,
    output logic                    m_freq_valid,
    output logic                    m_overflow
);
    import wsf_pkg::*;
    ctrl_t ctrl;
    stat_t stat;

    wsf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_last(s_last),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready),
        .stat(stat), .ctrl(ctrl));

    wsf_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctrl(ctrl), .stat(stat),
        .s_sample(s_sample), .s_timestamp_us(s_timestamp_us),
        .m_max_value(m_max_value), .m_min_value(m_min_value),
        .m_peak_to_peak(m_peak_to_peak), .m_crossing_count(m_crossing_count),
        .m_freq_q16(m_freq_q16), .m_freq_valid(m_freq_valid),
        .m_overflow(m_overflow));
endmodule
`default_nettype wire

[test/tb_top.sv]
// Self-checking testbench for the waveform span and frequency estimator.
`timescale 1ns / 1ps
module tb_top;
    import wsf_pkg::*;

    typedef struct {
        logic signed [15:0] max_value;
        logic signed [15:0] min_value;
        logic        [15:0] peak_to_peak;
        logic        [5:0]  crossing_count;
        logic        [41:0] freq_q16;
        logic               freq_valid;
        logic               overflow;
    } summary_t;

    localparam int IdleLimit = 20000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [15:0] s_sample = '0;
    logic [31:0] s_timestamp_us = '0;
    logic s_last = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_max_value, m_min_value;
    logic [15:0] m_peak_to_peak;
    logic [5:0] m_crossing_count;
    logic [41:0] m_freq_q16;
    logic m_freq_valid, m_overflow;

    waveform_span_and_frequency_top u_top (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic signed [15:0] blk_samples[BufferDepth];
    logic [31:0] blk_times[BufferDepth];
    int blk_fill;
    logic signed [15:0] blk_max, blk_min;
    logic blk_dropped;

    summary_t pending_summaries[$];
    int errors = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    bit hold_off = 1'b0;
    int idle_cycles = 0;

    function automatic void clear_block();
        blk_fill = 0;
        blk_max = 16'sd0;
        blk_min = 16'sd32767;
        blk_dropped = 1'b0;
    endfunction

    function automatic void predict_sample(logic signed [15:0] smp, logic [31:0] ts,
                                           logic lst);
        summary_t r;
        int mid2, cnt, c2, o2;
        logic [31:0] t_first, t_last, span;
        logic [63:0] num, q;
        bit armed;
        if (blk_fill < BufferDepth) begin
            blk_samples[blk_fill] = smp;
            blk_times[blk_fill] = ts;
            blk_fill++;
            if (smp > blk_max) blk_max = smp;
            if (smp < blk_min) blk_min = smp;
        end else begin
            blk_dropped = 1'b1;
        end
        if (!lst) return;
        mid2 = int'(blk_max) + int'(blk_min);
        cnt = 0;
        armed = 1'b1;
        t_first = '0;
        t_last = '0;
        for (int i = CrossingLag; i < blk_fill; i++) begin
            c2 = 2 * int'(blk_samples[i]);
            o2 = 2 * int'(blk_samples[i - CrossingLag]);
            if (cnt < MaxCrossings) begin
                if (c2 > mid2 && o2 < mid2 && armed) begin
                    if (cnt == 0) t_first = blk_times[i];
                    t_last = blk_times[i];
                    cnt++;
                    armed = 1'b0;
                end
                if (c2 < mid2 && !armed) armed = 1'b1;
            end
        end
        r.freq_q16 = '0;
        r.freq_valid = 1'b0;
        span = t_last - t_first;
        if (cnt >= 2 && span != 0) begin
            num = (64'(cnt - 1) * 64'd1000000) << 16;
            q = num / 64'(span);
            r.freq_q16 = (q > 64'(FreqMax)) ? FreqMax : q[41:0];
            r.freq_valid = 1'b1;
        end
        r.max_value = blk_max;
        r.min_value = blk_min;
        r.peak_to_peak = 16'(blk_max - blk_min);
        r.crossing_count = 6'(cnt);
        r.overflow = blk_dropped;
        pending_summaries.push_back(r);
        clear_block();
    endfunction

    // valid stays high between back-to-back transactions; it drops only when
    // the sender idles or waits for results
    task automatic send_sample(logic signed [15:0] smp, logic [31:0] ts, logic lst);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_timestamp_us <= ts;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_sample(smp, ts, lst);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_summaries.size() != 0) @(negedge aclk);
        repeat (5) @(negedge aclk);
    endtask

    // n samples of a square-ish wave, period p samples, timestamp step dt
    task automatic send_wave(int n, int p, int dt, int amp, bit noisy);
        logic [31:0] ts;
        int v;
        ts = $urandom;
        for (int i = 0; i < n; i++) begin
            v = ((i % p) < p / 2) ? amp : -amp;
            if (noisy) v += $urandom_range(amp / 4 + 1) - amp / 8;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            send_sample(16'(v), ts, i == n - 1);
            ts += 32'(dt);
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        summary_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_summaries.size() == 0) begin
                $error("unexpected result transaction");
                errors++;
            end else begin
                e = pending_summaries.pop_front();
                if (m_max_value !== e.max_value) begin
                    $error("max_value exp %0d got %0d", e.max_value, m_max_value); errors++;
                end
                if (m_min_value !== e.min_value) begin
                    $error("min_value exp %0d got %0d", e.min_value, m_min_value); errors++;
                end
                if (m_peak_to_peak !== e.peak_to_peak) begin
                    $error("peak_to_peak exp %0d got %0d", e.peak_to_peak, m_peak_to_peak);
                    errors++;
                end
                if (m_crossing_count !== e.crossing_count) begin
                    $error("crossing_count exp %0d got %0d", e.crossing_count,
                           m_crossing_count);
                    errors++;
                end
                if (m_freq_q16 !== e.freq_q16) begin
                    $error("freq_q16 exp %0d got %0d", e.freq_q16, m_freq_q16); errors++;
                end
                if (m_freq_valid !== e.freq_valid) begin
                    $error("freq_valid exp %0d got %0d", e.freq_valid, m_freq_valid);
                    errors++;
                end
                if (m_overflow !== e.overflow) begin
                    $error("overflow exp %0d got %0d", e.overflow, m_overflow); errors++;
                end
            end
        end
    end

    // receiver readiness
    always @(negedge aclk) begin
        m_ready <= !hold_off && ($urandom_range(99) >= receiver_stall_pct);
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IdleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic test_directed();
        logic [31:0] ts;
        // single sample blocks at extremes
        send_sample(16'sh7FFF, 32'hFFFF_FFFF, 1'b1);
        send_sample(-16'sd32768, 32'h0, 1'b1);
        send_sample(16'sd0, 32'h5555_AAAA, 1'b1);
        // all negative: max stays at zero
        send_sample(-16'sd5, 32'd1, 1'b0);
        send_sample(-16'sd9, 32'd2, 1'b1);
        // full-scale square wave, several crossings, wrapping timestamps
        ts = 32'hFFFF_FFF0;
        for (int i = 0; i < 24; i++) begin
            send_sample((i % 6 < 3) ? -16'sd32768 : 16'sh7FFF, ts, i == 23);
            ts += 32'd3;
        end
        // zero span: identical timestamps
        for (int i = 0; i < 24; i++)
            send_sample((i % 6 < 3) ? -16'sd100 : 16'sd100, 32'd77, i == 23);
        // span of 1 us with several crossings
        for (int i = 0; i < 30; i++)
            send_sample((i % 6 < 3) ? -16'sd100 : 16'sd100, (i < 12) ? 32'd0 : 32'd1,
                        i == 29);
        wait_drained();
    endtask

    task automatic test_overflow();
        // overfill the store; dropped samples must not touch max or min.
        // The 12-sample period also runs well past the crossing limit.
        for (int i = 0; i < BufferDepth + 6; i++)
            send_sample((i >= BufferDepth) ? 16'sh7FFF :
                        16'((((i % 12) < 6) ? -1000 : 1000) + i % 7), 32'(3 * i),
                        i == BufferDepth + 5);
        wait_drained();
    endtask

    task automatic test_back_pressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(negedge aclk);
                hold_off = 1'b0;
            end
            begin
                send_wave(6, 4, 5, 300, 1'b0);
                send_wave(40, 8, 7, 3000, 1'b1);
            end
        join
        wait_drained();
    endtask

    task automatic test_random(int n_items);
        int sent, n, p, amp;
        sent = 0;
        while (sent < n_items) begin
            case (sent * 4 / n_items)
                0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
                1: begin sender_idle_pct = 72; receiver_stall_pct = 0; end
                2: begin sender_idle_pct = 0; receiver_stall_pct = 72; end
                default: begin sender_idle_pct = 16; receiver_stall_pct = 16; end
            endcase
            n = $urandom_range(10, 1);
            if ($urandom_range(9) < 7) begin
                p = $urandom_range(14, 2);
                amp = $urandom_range(32767, 1);
                send_wave(n, p, $urandom_range(50000), amp, $urandom_range(1));
            end else begin
                for (int i = 0; i < n; i++)
                    send_sample(16'($urandom), $urandom, i == n - 1);
            end
            sent += n;
        end
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        wait_drained();
    endtask

    initial begin
        clear_block();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_overflow();
        test_back_pressure();
        test_random(100);
        repeat (100) @(negedge aclk);
        if (errors == 0 && pending_summaries.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
